@@ rtl/cle_pkg.sv @@
// cle_pkg: shared constants, codes and beat / control structs for the circular list engine
// no dependencies; used by every module under rtl
`timescale 1ns / 1ps

package cle_pkg;

    // pool geometry
    localparam int CAPACITY   = 256;
    localparam int ELEM_WIDTH = 32;
    localparam int SLOT_W     = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);

    // request codes
    localparam logic [2:0] OP_INSERT = 3'd0;
    localparam logic [2:0] OP_DELETE = 3'd1;
    localparam logic [2:0] OP_NEXT   = 3'd2;
    localparam logic [2:0] OP_PREV   = 3'd3;
    localparam logic [2:0] OP_READ   = 3'd4;

    // result status codes
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    // request beat
    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] item_value;
    } cle_in_t;

    // result beat
    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] element_out;
        logic [8:0]  list_length;
    } cle_out_t;

    // write side of the link / value store, one port per memory
    typedef struct packed {
        logic                  next_we;
        logic [SLOT_W-1:0]     next_addr;
        logic [SLOT_W-1:0]     next_data;
        logic                  prev_we;
        logic [SLOT_W-1:0]     prev_addr;
        logic [SLOT_W-1:0]     prev_data;
        logic                  val_we;
        logic [SLOT_W-1:0]     val_addr;
        logic [ELEM_WIDTH-1:0] val_data;
    } cle_link_wr_t;

    // registered read data of the link / value store
    typedef struct packed {
        logic [SLOT_W-1:0]     next_slot;
        logic [SLOT_W-1:0]     prev_slot;
        logic [ELEM_WIDTH-1:0] value;
    } cle_link_rd_t;

    // control of the free-slot stack
    typedef struct packed {
        logic              rd_en;
        logic [SLOT_W-1:0] rd_idx;
        logic              pop_commit;
        logic              push_we;
        logic [SLOT_W-1:0] push_idx;
        logic [SLOT_W-1:0] push_slot;
    } cle_free_ctl_t;

endpackage

@@ rtl/cle_link_store.sv @@
// cle_link_store: node value, successor and predecessor memories of the list pool
// depends on cle_pkg; one write port and one registered read port per memory
`timescale 1ns / 1ps

module cle_link_store (
    input  logic                      aclk,
    input  logic                      rd_en,
    input  logic [cle_pkg::SLOT_W-1:0] rd_addr,
    input  cle_pkg::cle_link_wr_t     wr,
    output cle_pkg::cle_link_rd_t     rd
);

    logic [cle_pkg::SLOT_W-1:0]     next_mem [cle_pkg::CAPACITY];
    logic [cle_pkg::SLOT_W-1:0]     prev_mem [cle_pkg::CAPACITY];
    logic [cle_pkg::ELEM_WIDTH-1:0] val_mem  [cle_pkg::CAPACITY];

    logic [cle_pkg::SLOT_W-1:0]     next_rd_reg;
    logic [cle_pkg::SLOT_W-1:0]     prev_rd_reg;
    logic [cle_pkg::ELEM_WIDTH-1:0] val_rd_reg;

    // successor links
    always_ff @(posedge aclk) begin
        if (wr.next_we) begin
            next_mem[wr.next_addr] <= wr.next_data;
        end
        if (rd_en) begin
            next_rd_reg <= next_mem[rd_addr];
        end
    end

    // predecessor links
    always_ff @(posedge aclk) begin
        if (wr.prev_we) begin
            prev_mem[wr.prev_addr] <= wr.prev_data;
        end
        if (rd_en) begin
            prev_rd_reg <= prev_mem[rd_addr];
        end
    end

    // element values
    always_ff @(posedge aclk) begin
        if (wr.val_we) begin
            val_mem[wr.val_addr] <= wr.val_data;
        end
        if (rd_en) begin
            val_rd_reg <= val_mem[rd_addr];
        end
    end

    assign rd = '{next_slot: next_rd_reg, prev_slot: prev_rd_reg, value: val_rd_reg};

endmodule

@@ rtl/cle_free_stack.sv @@
// cle_free_stack: stack of free pool slots in a memory, with a low-water mark
// depends on cle_pkg; entries below the mark were never written and read as their own index
`timescale 1ns / 1ps

module cle_free_stack (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  cle_pkg::cle_free_ctl_t     ctl,
    output logic [cle_pkg::SLOT_W-1:0] pop_slot
);

    logic [cle_pkg::SLOT_W-1:0] stack_mem [cle_pkg::CAPACITY];
    logic [cle_pkg::SLOT_W-1:0] rd_data_reg;
    logic [cle_pkg::SLOT_W-1:0] rd_idx_reg;
    logic                       fresh_reg;
    logic [cle_pkg::CNT_W-1:0]  low_mark_reg;
    logic [cle_pkg::CNT_W-1:0]  low_mark_next;

    // stack memory, registered read
    always_ff @(posedge aclk) begin
        if (ctl.push_we) begin
            stack_mem[ctl.push_idx] <= ctl.push_slot;
        end
        if (ctl.rd_en) begin
            rd_data_reg <= stack_mem[ctl.rd_idx];
            rd_idx_reg  <= ctl.rd_idx;
            fresh_reg   <= (cle_pkg::CNT_W'(ctl.rd_idx) < low_mark_reg);
        end
    end

    // lowest stack depth reached since reset
    always_comb begin
        low_mark_next = low_mark_reg;
        if (ctl.pop_commit && fresh_reg) begin
            low_mark_next = cle_pkg::CNT_W'(rd_idx_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_mark_reg <= cle_pkg::CNT_W'(cle_pkg::CAPACITY);
        end else begin
            low_mark_reg <= low_mark_next;
        end
    end

    // untouched entries still hold the reset order
    assign pop_slot = fresh_reg ? rd_idx_reg : rd_data_reg;

endmodule

@@ rtl/circular_list_engine_unit.sv @@
// circular_list_engine_unit: top level of the circular doubly linked list engine
// depends on cle_pkg, cle_link_store, cle_free_stack
`timescale 1ns / 1ps
//
// Usage:
// - s_valid / s_ready / s_data carry request beats (op, item_value); m_valid / m_ready /
//   m_data carry one result beat (status, element_out, list_length) per request.
// - A request is taken only while the engine is idle. The accept cycle reads the current
//   node's links and value and the top of the free-slot stack from the memories; the next
//   cycle applies the operation and writes back; insert into a non-empty list makes the
//   second pair of link writes in the ST_LINK state, as each memory has a single write port.
// - The result is registered through ST_EXEC, then ST_LINK for such inserts, then ST_RESP.
//   A new request is taken only once the engine is back in idle, set by the read-then-write
//   sequence through the link memories with their single write ports.
// - The result sits in an output register; the next request is accepted and worked on
//   while it waits. A stalled receiver only holds the engine once a second result is done.
// - Reset (synchronous, aresetn low) empties the list, puts the current position at slot
//   zero and returns all slots to the free stack at once; no clearing pass is needed.
// - Reads never overlap a write to the same entry: writes finish before the engine returns
//   to idle, so no forwarding path exists.
//

module circular_list_engine_unit (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  cle_pkg::cle_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output cle_pkg::cle_out_t m_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_LINK,
        ST_RESP
    } state_t;

    state_t                          state_reg, state_next;
    logic [cle_pkg::CNT_W-1:0]       count_reg, count_next;
    logic [cle_pkg::SLOT_W-1:0]      cur_reg, cur_next;
    logic [cle_pkg::SLOT_W-1:0]      old_cur_reg, old_cur_next;
    logic [cle_pkg::SLOT_W-1:0]      after_reg, after_next;
    logic [2:0]                      op_reg, op_next;
    logic [cle_pkg::ELEM_WIDTH-1:0]  val_reg, val_next;
    logic [1:0]                      res_status_reg, res_status_next;
    logic [cle_pkg::ELEM_WIDTH-1:0]  res_elem_reg, res_elem_next;
    logic                            m_valid_reg, m_valid_next;
    cle_pkg::cle_out_t               m_data_reg, m_data_next;

    logic                            accept;
    logic                            is_empty;
    cle_pkg::cle_link_wr_t           link_wr;
    cle_pkg::cle_link_rd_t           link_rd;
    cle_pkg::cle_free_ctl_t          free_ctl;
    logic [cle_pkg::SLOT_W-1:0]      pop_slot;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign is_empty = (count_reg == '0);

    cle_link_store u_link_store (
        .aclk    (aclk),
        .rd_en   (accept),
        .rd_addr (cur_reg),
        .wr      (link_wr),
        .rd      (link_rd)
    );

    cle_free_stack u_free_stack (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (free_ctl),
        .pop_slot (pop_slot)
    );

    // operation sequencer
    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        cur_next        = cur_reg;
        old_cur_next    = old_cur_reg;
        after_next      = after_reg;
        op_next         = op_reg;
        val_next        = val_reg;
        res_status_next = res_status_reg;
        res_elem_next   = res_elem_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        link_wr         = '0;
        free_ctl        = '0;

        // free stack top is read on every accepted beat
        free_ctl.rd_en  = accept;
        free_ctl.rd_idx = cle_pkg::SLOT_W'(cle_pkg::CNT_W'(cle_pkg::CAPACITY - 1) - count_reg);

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    op_next    = s_data.op;
                    val_next   = s_data.item_value[cle_pkg::ELEM_WIDTH-1:0];
                    state_next = ST_EXEC;
                end
            end

            ST_EXEC: begin
                res_status_next = cle_pkg::STATUS_OK;
                res_elem_next   = '0;
                state_next      = ST_RESP;
                case (op_reg)
                    cle_pkg::OP_INSERT: begin
                        if (count_reg == cle_pkg::CNT_W'(cle_pkg::CAPACITY)) begin
                            res_status_next = cle_pkg::STATUS_FULL;
                        end else begin
                            free_ctl.pop_commit = 1'b1;
                            link_wr.val_we      = 1'b1;
                            link_wr.val_addr    = pop_slot;
                            link_wr.val_data    = val_reg;
                            link_wr.next_we     = 1'b1;
                            link_wr.next_addr   = pop_slot;
                            link_wr.prev_we     = 1'b1;
                            link_wr.prev_addr   = pop_slot;
                            if (is_empty) begin
                                // one-node ring
                                link_wr.next_data = pop_slot;
                                link_wr.prev_data = pop_slot;
                            end else begin
                                link_wr.next_data = link_rd.next_slot;
                                link_wr.prev_data = cur_reg;
                                old_cur_next      = cur_reg;
                                after_next        = link_rd.next_slot;
                                state_next        = ST_LINK;
                            end
                            cur_next   = pop_slot;
                            count_next = count_reg + cle_pkg::CNT_W'(1);
                        end
                    end

                    cle_pkg::OP_DELETE: begin
                        if (is_empty) begin
                            res_status_next = cle_pkg::STATUS_EMPTY;
                        end else begin
                            res_elem_next      = link_rd.value;
                            free_ctl.push_we   = 1'b1;
                            free_ctl.push_idx  = cle_pkg::SLOT_W'(
                                cle_pkg::CNT_W'(cle_pkg::CAPACITY) - count_reg);
                            free_ctl.push_slot = cur_reg;
                            count_next         = count_reg - cle_pkg::CNT_W'(1);
                            if (count_reg == cle_pkg::CNT_W'(1)) begin
                                cur_next = '0;
                            end else begin
                                // unlink: before.next = after, after.prev = before
                                link_wr.next_we   = 1'b1;
                                link_wr.next_addr = link_rd.prev_slot;
                                link_wr.next_data = link_rd.next_slot;
                                link_wr.prev_we   = 1'b1;
                                link_wr.prev_addr = link_rd.next_slot;
                                link_wr.prev_data = link_rd.prev_slot;
                                cur_next          = link_rd.next_slot;
                            end
                        end
                    end

                    cle_pkg::OP_NEXT: begin
                        if (is_empty) begin
                            res_status_next = cle_pkg::STATUS_EMPTY;
                        end else begin
                            cur_next = link_rd.next_slot;
                        end
                    end

                    cle_pkg::OP_PREV: begin
                        if (is_empty) begin
                            res_status_next = cle_pkg::STATUS_EMPTY;
                        end else begin
                            cur_next = link_rd.prev_slot;
                        end
                    end

                    cle_pkg::OP_READ: begin
                        if (is_empty) begin
                            res_status_next = cle_pkg::STATUS_EMPTY;
                        end else begin
                            res_elem_next = link_rd.value;
                        end
                    end

                    default: begin
                        // unused codes leave everything as it is
                        res_status_next = cle_pkg::STATUS_OK;
                    end
                endcase
            end

            ST_LINK: begin
                // splice new node in: old.next = new, after.prev = new
                link_wr.next_we   = 1'b1;
                link_wr.next_addr = old_cur_reg;
                link_wr.next_data = cur_reg;
                link_wr.prev_we   = 1'b1;
                link_wr.prev_addr = after_reg;
                link_wr.prev_data = cur_reg;
                state_next        = ST_RESP;
            end

            ST_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next            = 1'b1;
                    m_data_next.status      = res_status_reg;
                    m_data_next.element_out = res_elem_reg;
                    m_data_next.list_length = count_reg;
                    state_next              = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            cur_reg        <= '0;
            old_cur_reg    <= '0;
            after_reg      <= '0;
            op_reg         <= '0;
            val_reg        <= '0;
            res_status_reg <= cle_pkg::STATUS_OK;
            res_elem_reg   <= '0;
            m_valid_reg    <= 1'b0;
            m_data_reg     <= '0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            cur_reg        <= cur_next;
            old_cur_reg    <= old_cur_next;
            after_reg      <= after_next;
            op_reg         <= op_next;
            val_reg        <= val_next;
            res_status_reg <= res_status_next;
            res_elem_reg   <= res_elem_next;
            m_valid_reg    <= m_valid_next;
            m_data_reg     <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // element count never passes the pool size
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= cle_pkg::CNT_W'(cle_pkg::CAPACITY))
        else $error("element count above capacity");

    // a full report only comes with a full pool
    a_full_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status == cle_pkg::STATUS_FULL)
        |-> m_data.list_length == 9'(cle_pkg::CAPACITY))
        else $error("full status with pool not full");

    // an empty report carries no element and zero length
    a_empty_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status == cle_pkg::STATUS_EMPTY)
        |-> (m_data.list_length == '0) && (m_data.element_out == '0))
        else $error("empty status with element or length");

    // an empty list keeps its position at slot zero
    a_empty_cur: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) |-> (cur_reg == '0))
        else $error("current slot not zero on empty list");

endmodule

@@ dv/tb_circular_list_engine_unit.sv @@
// tb_circular_list_engine_unit: self-checking bench for the circular list engine
// depends on cle_pkg and circular_list_engine_unit; keeps its own ring model to predict results
`timescale 1ns / 1ps

module tb_circular_list_engine_unit;

    localparam int          CYCLE_LIMIT     = 600000;
    localparam int          DRAIN_CYCLES    = 20;
    localparam int          RANDOM_ITEMS    = 900;
    localparam int          MAX_GAP         = 13;
    localparam logic [2:0]  OP_FIRST_UNUSED = 3'd5;
    localparam logic [2:0]  OP_MID_UNUSED   = 3'd6;
    localparam logic [2:0]  OP_LAST_CODE    = 3'd7;

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    cle_pkg::cle_in_t  s_data;
    logic              m_valid;
    logic              m_ready;
    cle_pkg::cle_out_t m_data;

    // ring model state
    logic [cle_pkg::ELEM_WIDTH-1:0] pool_value  [cle_pkg::CAPACITY];
    logic [cle_pkg::SLOT_W-1:0]     succ_slot   [cle_pkg::CAPACITY];
    logic [cle_pkg::SLOT_W-1:0]     pred_slot   [cle_pkg::CAPACITY];
    logic [cle_pkg::SLOT_W-1:0]     spare_stack [cle_pkg::CAPACITY];
    logic [cle_pkg::CNT_W-1:0]      spare_top;
    logic [cle_pkg::SLOT_W-1:0]     cur_slot;
    logic [cle_pkg::CNT_W-1:0]      live_count;

    cle_pkg::cle_out_t pending_results[$];

    // run bookkeeping
    bit steady;
    int receiver_hold;
    int err_count;
    int cycle_count;
    int sent_count;
    int checked_count;
    int full_hits;
    int empty_hits;
    int peak_length;

    circular_list_engine_unit i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // timeout guard
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                     pending_results.size());
            $display("circular_list_engine_unit test failed");
            $finish;
        end
    end

    // apply one request to the ring model and return the result it should produce
    function automatic cle_pkg::cle_out_t apply_list_op(cle_pkg::cle_in_t req);
        cle_pkg::cle_out_t          res;
        logic [cle_pkg::SLOT_W-1:0] slot;
        logic [cle_pkg::SLOT_W-1:0] after;
        logic [cle_pkg::SLOT_W-1:0] prior;
        res = '0;
        if (req.op == cle_pkg::OP_INSERT) begin
            if (live_count == cle_pkg::CAPACITY) begin
                res.status = cle_pkg::STATUS_FULL;
            end else begin
                spare_top = spare_top - cle_pkg::CNT_W'(1);
                slot = spare_stack[spare_top[cle_pkg::SLOT_W-1:0]];
                pool_value[slot] = req.item_value;
                if (live_count == 0) begin
                    succ_slot[slot] = slot;
                    pred_slot[slot] = slot;
                end else begin
                    after = succ_slot[cur_slot];
                    succ_slot[slot] = after;
                    pred_slot[slot] = cur_slot;
                    succ_slot[cur_slot] = slot;
                    pred_slot[after] = slot;
                end
                cur_slot = slot;
                live_count = live_count + cle_pkg::CNT_W'(1);
            end
        end else if (req.op <= cle_pkg::OP_READ) begin
            if (live_count == 0) begin
                res.status = cle_pkg::STATUS_EMPTY;
            end else begin
                case (req.op)
                    cle_pkg::OP_DELETE: begin
                        after = succ_slot[cur_slot];
                        prior = pred_slot[cur_slot];
                        res.element_out = pool_value[cur_slot];
                        spare_stack[spare_top[cle_pkg::SLOT_W-1:0]] = cur_slot;
                        spare_top = spare_top + cle_pkg::CNT_W'(1);
                        live_count = live_count - cle_pkg::CNT_W'(1);
                        if (live_count == 0) begin
                            cur_slot = '0;
                        end else begin
                            succ_slot[prior] = after;
                            pred_slot[after] = prior;
                            cur_slot = after;
                        end
                    end
                    cle_pkg::OP_NEXT: cur_slot = succ_slot[cur_slot];
                    cle_pkg::OP_PREV: cur_slot = pred_slot[cur_slot];
                    default: res.element_out = pool_value[cur_slot];
                endcase
            end
        end
        // unused codes fall through with status ok and nothing changed
        res.list_length = live_count;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h (result %0d)",
                 $realtime, what, got, want, checked_count);
        err_count++;
    endtask

    // predict on every accepted request, compare every accepted result
    always @(posedge aclk) begin
        cle_pkg::cle_out_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                pending_results.push_back(apply_list_op(s_data));
            end
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected result beat", m_data.element_out, '0);
                end else begin
                    want = pending_results.pop_front();
                    if (m_data.status !== want.status)
                        report_mismatch("status", 32'(m_data.status), 32'(want.status));
                    if (m_data.element_out !== want.element_out)
                        report_mismatch("element_out", m_data.element_out, want.element_out);
                    if (m_data.list_length !== want.list_length)
                        report_mismatch("list_length", 32'(m_data.list_length),
                                        32'(want.list_length));
                    if (want.status == cle_pkg::STATUS_FULL) full_hits++;
                    if (want.status == cle_pkg::STATUS_EMPTY) empty_hits++;
                    if (int'(want.list_length) > peak_length)
                        peak_length = int'(want.list_length);
                end
                checked_count++;
            end
        end
    end

    // result side: random stall per beat, plus an optional long hold
    initial begin
        int stall;
        m_ready = 1'b0;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            if (receiver_hold > 0) begin
                m_ready = 1'b0;
                repeat (receiver_hold) @(negedge aclk);
                receiver_hold = 0;
            end
            stall = steady ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0) begin
                m_ready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready = 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // offer one request beat and wait for it to be taken; valid stays high when no gap follows
    task automatic drive_request(input logic [2:0] op, input logic [31:0] value);
        int gap;
        gap = steady ? 0 : $urandom_range(0, MAX_GAP);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_data.op = op;
        s_data.item_value = value;
        do @(posedge aclk); while (!s_ready);
        sent_count++;
    endtask

    function automatic logic [31:0] pick_value();
        logic [31:0] one_hot;
        one_hot = 32'd1 << $urandom_range(0, 31);
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return one_hot;
            3:       return ~one_hot;
            default: return $urandom;
        endcase
    endfunction

    // op mix: a few unused codes, then insert / delete by the given weights, rest walks or reads
    function automatic logic [2:0] pick_op(int insert_pct, int delete_pct);
        int r;
        if ($urandom_range(0, 99) < 4)
            return 3'($urandom_range(OP_FIRST_UNUSED, OP_LAST_CODE));
        r = $urandom_range(0, 99);
        if (r < insert_pct) return cle_pkg::OP_INSERT;
        if (r < insert_pct + delete_pct) return cle_pkg::OP_DELETE;
        case ($urandom_range(0, 2))
            0:       return cle_pkg::OP_NEXT;
            1:       return cle_pkg::OP_PREV;
            default: return cle_pkg::OP_READ;
        endcase
    endfunction

    // empty list, single-node ring, last delete, extreme values, unused codes
    task automatic test_empty_and_single_node();
        drive_request(cle_pkg::OP_READ, '0);
        drive_request(cle_pkg::OP_DELETE, '1);
        drive_request(cle_pkg::OP_NEXT, '0);
        drive_request(cle_pkg::OP_PREV, '1);
        drive_request(OP_FIRST_UNUSED, '1);
        drive_request(OP_MID_UNUSED, '0);
        drive_request(OP_LAST_CODE, 32'hA5A5_5A5A);
        drive_request(cle_pkg::OP_INSERT, '0);
        drive_request(cle_pkg::OP_READ, '1);
        drive_request(cle_pkg::OP_NEXT, '0);
        drive_request(cle_pkg::OP_PREV, '0);
        drive_request(cle_pkg::OP_DELETE, '0);
        drive_request(cle_pkg::OP_READ, '0);
        drive_request(cle_pkg::OP_INSERT, '1);
        drive_request(cle_pkg::OP_INSERT, '0);
        drive_request(cle_pkg::OP_INSERT, 32'hA5A5_A5A5);
        drive_request(cle_pkg::OP_INSERT, 32'h5A5A_5A5A);
        drive_request(cle_pkg::OP_NEXT, '0);
        drive_request(cle_pkg::OP_READ, '0);
        drive_request(cle_pkg::OP_PREV, '0);
        drive_request(cle_pkg::OP_PREV, '0);
        drive_request(cle_pkg::OP_DELETE, '0);
        drive_request(cle_pkg::OP_READ, '0);
        drive_request(OP_FIRST_UNUSED, '1);
    endtask

    // fill the pool, poke at the full ring, then empty it again
    task automatic test_fill_to_capacity();
        steady = 1'b1;
        while (live_count < cle_pkg::CAPACITY) drive_request(cle_pkg::OP_INSERT, pick_value());
        steady = 1'b0;
        drive_request(cle_pkg::OP_INSERT, '1);
        drive_request(cle_pkg::OP_READ, '0);
        drive_request(cle_pkg::OP_INSERT, '0);
        drive_request(cle_pkg::OP_PREV, '0);
        drive_request(cle_pkg::OP_DELETE, '0);
        drive_request(cle_pkg::OP_INSERT, 32'hDEAD_BEEF);
        drive_request(cle_pkg::OP_INSERT, '1);
        drive_request(cle_pkg::OP_NEXT, '0);
        while (live_count > 0) begin
            if ($urandom_range(0, 3) == 0)
                drive_request(pick_op(0, 0), pick_value());
            else
                drive_request(cle_pkg::OP_DELETE, pick_value());
        end
        drive_request(cle_pkg::OP_DELETE, '0);
    endtask

    // receiver stalls for a long stretch while requests keep coming back to back
    task automatic test_receiver_backpressure();
        receiver_hold = 300;
        steady = 1'b1;
        repeat (24) drive_request(pick_op(50, 15), pick_value());
        steady = 1'b0;
    endtask

    // random phases that grow, shrink or churn the ring, some without idle cycles
    task automatic test_random_mix();
        int counted;
        int phase_left;
        int insert_pct;
        int delete_pct;
        logic [2:0] op;
        counted = 0;
        phase_left = 0;
        insert_pct = 30;
        delete_pct = 25;
        while (counted < RANDOM_ITEMS) begin
            if (phase_left == 0) begin
                phase_left = $urandom_range(40, 120);
                steady = ($urandom_range(0, 4) == 0);
                case ($urandom_range(0, 2))
                    0: begin insert_pct = 60; delete_pct = 10; end
                    1: begin insert_pct = 10; delete_pct = 55; end
                    default: begin insert_pct = 30; delete_pct = 25; end
                endcase
            end
            op = pick_op(insert_pct, delete_pct);
            drive_request(op, pick_value());
            if (op <= cle_pkg::OP_READ) counted++;
            phase_left--;
        end
        steady = 1'b0;
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        steady = 1'b0;
        receiver_hold = 0;
        err_count = 0;
        cycle_count = 0;
        sent_count = 0;
        checked_count = 0;
        full_hits = 0;
        empty_hits = 0;
        peak_length = 0;
        // model matches the reset state of the engine
        for (int i = 0; i < cle_pkg::CAPACITY; i++) begin
            pool_value[i] = '0;
            succ_slot[i] = '0;
            pred_slot[i] = '0;
            spare_stack[i] = cle_pkg::SLOT_W'(i);
        end
        spare_top = cle_pkg::CNT_W'(cle_pkg::CAPACITY);
        cur_slot = '0;
        live_count = '0;

        repeat (6) @(negedge aclk);
        aresetn = 1'b1;

        test_empty_and_single_node();
        test_fill_to_capacity();
        test_receiver_backpressure();
        test_random_mix();

        @(negedge aclk);
        s_valid = 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d requests and %0d checked results in %0d cycles",
                 sent_count, checked_count, cycle_count);
        $display("ring peaked at %0d nodes; %0d full and %0d empty responses; %0d errors",
                 peak_length, full_hits, empty_hits, err_count);
        if (err_count == 0) begin
            $display("circular_list_engine_unit test passed");
        end else begin
            $display("circular_list_engine_unit test failed");
        end
        $finish;
    end

endmodule
